/* hw/rtl/dspwm_pkg.sv */
`default_nettype none

package dspwm_pkg;

   localparam int unsigned DUTY_W   = 8;
   localparam int unsigned SENSOR_W = 10;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 10;
   localparam int unsigned BUTTON_N = 5;

   localparam logic [DUTY_W-1:0]   PERIOD_RST    = 8'd200;
   localparam logic [DUTY_W-1:0]   DUTY_MIN_RST  = 8'd10;
   localparam logic [DUTY_W-1:0]   DUTY_MAX_RST  = 8'd21;
   localparam logic [DUTY_W-1:0]   AUTO_DUTY_RST = 8'd20;
   localparam logic [SENSOR_W-1:0] THRESH_RST    = 10'd10;
   localparam logic [DUTY_W-1:0]   DUTY_RST      = 8'd10;

   // bit positions in the held-button vector
   localparam int unsigned BTN_TOGGLE = 0;
   localparam int unsigned BTN_UP_A   = 1;
   localparam int unsigned BTN_DOWN_A = 2;
   localparam int unsigned BTN_UP_B   = 3;
   localparam int unsigned BTN_DOWN_B = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PERIOD_TICKS     = 3'd0,
      CSR_DUTY_MIN         = 3'd1,
      CSR_DUTY_MAX         = 3'd2,
      CSR_AUTOPILOT_DUTY   = 3'd3,
      CSR_SENSOR_THRESHOLD = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic                mode;
      logic                toggle_level;
      logic                up_a_level;
      logic                down_a_level;
      logic                up_b_level;
      logic                down_b_level;
      logic [SENSOR_W-1:0] sensor_a;
      logic [SENSOR_W-1:0] sensor_c;
   } req_type;

   typedef struct packed {
      logic              pulse_a;
      logic              pulse_b;
      logic              autopilot_on;
      logic [DUTY_W-1:0] duty_a_now;
      logic [DUTY_W-1:0] duty_b_now;
   } rsp_type;

endpackage

`default_nettype wire

/* hw/rtl/dual_servo_pwm_with_trim_top.sv */
`default_nettype none

// channel | direction | handshake           | payload
// req     | in        | req_valid/req_stall | req_data (dspwm_pkg::req_type)
// rsp     | out       | rsp_valid/rsp_stall | rsp_data (dspwm_pkg::rsp_type)
// csr     | in        | csr_we              | csr_index, csr_wdata
//
// one word per cycle: each tick or poll is worked out in the cycle it is taken
// and its result sits in the output register from the next cycle on.
// the output register is the only stage; the next word is taken whenever it is
// empty or being emptied, so a stalled result holds off the input only.
// synchronous reset restores register and state defaults and empties the output.

module dual_servo_pwm_with_trim_top (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire  dspwm_pkg::req_type         req_data,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output dspwm_pkg::rsp_type               rsp_data,
   input  wire                              csr_we,
   input  wire  [dspwm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire  [dspwm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dspwm_pkg::*;

   logic [DUTY_W-1:0]   period_ff, duty_min_ff, duty_max_ff, auto_duty_ff;
   logic [SENSOR_W-1:0] thresh_ff;

   logic [DUTY_W-1:0]   tick_count_ff, tick_count_in;
   logic                level_a_ff, level_a_in, level_b_ff, level_b_in;
   logic [DUTY_W-1:0]   duty_a_ff, duty_a_in, duty_b_ff, duty_b_in;
   logic                autopilot_ff, autopilot_in;
   logic [BUTTON_N-1:0] held_ff, held_in;

   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;

   logic                accept;
   logic [DUTY_W:0]     tick_inc;
   logic [BUTTON_N-1:0] levels, press;
   logic [DUTY_W-1:0]   da, db;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign levels = {req_data.down_b_level, req_data.up_b_level, req_data.down_a_level,
                    req_data.up_a_level, req_data.toggle_level};
   // active low buttons: a press counts only when not already held
   assign press  = ~held_ff & ~levels;

   assign tick_inc = {1'b0, tick_count_ff} + {{DUTY_W{1'b0}}, 1'b1};

   always_comb begin
      tick_count_in = tick_count_ff;
      level_a_in    = level_a_ff;
      level_b_in    = level_b_ff;
      duty_a_in     = duty_a_ff;
      duty_b_in     = duty_b_ff;
      autopilot_in  = autopilot_ff;
      held_in       = held_ff;
      da            = duty_a_ff;
      db            = duty_b_ff;
      if (!req_data.mode) begin
         if (tick_inc >= {1'b0, period_ff}) begin
            tick_count_in = '0;
         end else begin
            tick_count_in = tick_inc[DUTY_W-1:0];
         end
         if (tick_count_in == '0) begin
            level_a_in = 1'b1;
            level_b_in = 1'b1;
         end
         if (tick_count_in == duty_a_ff) level_a_in = 1'b0;
         if (tick_count_in == duty_b_ff) level_b_in = 1'b0;
      end else begin
         if (autopilot_ff) begin
            priority if (req_data.sensor_a > thresh_ff) begin
               da = auto_duty_ff;
            end else if (req_data.sensor_c > thresh_ff) begin
               db = auto_duty_ff;
            end else begin
               da = duty_min_ff;
               db = duty_min_ff;
            end
         end
         // trim up then down, in that order, on the overridden duties
         if (press[BTN_UP_A] && da < duty_max_ff)   da = da + 8'd1;
         if (press[BTN_DOWN_A] && da > duty_min_ff) da = da - 8'd1;
         if (press[BTN_UP_B] && db < duty_max_ff)   db = db + 8'd1;
         if (press[BTN_DOWN_B] && db > duty_min_ff) db = db - 8'd1;
         duty_a_in    = da;
         duty_b_in    = db;
         autopilot_in = autopilot_ff ^ press[BTN_TOGGLE];
         held_in      = ~levels;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= PERIOD_RST;
         duty_min_ff  <= DUTY_MIN_RST;
         duty_max_ff  <= DUTY_MAX_RST;
         auto_duty_ff <= AUTO_DUTY_RST;
         thresh_ff    <= THRESH_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PERIOD_TICKS:     period_ff    <= csr_wdata[DUTY_W-1:0];
            CSR_DUTY_MIN:         duty_min_ff  <= csr_wdata[DUTY_W-1:0];
            CSR_DUTY_MAX:         duty_max_ff  <= csr_wdata[DUTY_W-1:0];
            CSR_AUTOPILOT_DUTY:   auto_duty_ff <= csr_wdata[DUTY_W-1:0];
            CSR_SENSOR_THRESHOLD: thresh_ff    <= csr_wdata[SENSOR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= '0;
         level_a_ff    <= 1'b0;
         level_b_ff    <= 1'b0;
         duty_a_ff     <= DUTY_RST;
         duty_b_ff     <= DUTY_RST;
         autopilot_ff  <= 1'b0;
         held_ff       <= '0;
      end else if (accept) begin
         tick_count_ff <= tick_count_in;
         level_a_ff    <= level_a_in;
         level_b_ff    <= level_b_in;
         duty_a_ff     <= duty_a_in;
         duty_b_ff     <= duty_b_in;
         autopilot_ff  <= autopilot_in;
         held_ff       <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff.pulse_a      <= level_a_in;
         rsp_data_ff.pulse_b      <= level_b_in;
         rsp_data_ff.autopilot_on <= autopilot_in;
         rsp_data_ff.duty_a_now   <= duty_a_in;
         rsp_data_ff.duty_b_now   <= duty_b_in;
      end
   end

endmodule

`default_nettype wire

/* test/dual_servo_pwm_with_trim_top_tb.sv */
`timescale 1ns / 1ps

module dual_servo_pwm_with_trim_top_tb;
   import dspwm_pkg::*;

   localparam logic TICK  = 1'b0;
   localparam logic POLL  = 1'b1;
   localparam logic PRESS = 1'b0;
   localparam logic REL   = 1'b1;
   localparam int unsigned SENSOR_MAX = (1 << SENSOR_W) - 1;

   // shadow copy of the servo state, predicts each result word
   class servo_shadow;
      logic [DUTY_W-1:0]   period, dmin, dmax, auto_duty;
      logic [SENSOR_W-1:0] threshold;
      logic [DUTY_W-1:0]   count, duty_a, duty_b;
      logic                lvl_a, lvl_b, engaged;
      logic [BUTTON_N-1:0] held;
      rsp_type             due[$];
      int unsigned         faults;

      function new();
         period    = PERIOD_RST;
         dmin      = DUTY_MIN_RST;
         dmax      = DUTY_MAX_RST;
         auto_duty = AUTO_DUTY_RST;
         threshold = THRESH_RST;
         count     = '0;
         duty_a    = DUTY_RST;
         duty_b    = DUTY_RST;
         lvl_a     = 1'b0;
         lvl_b     = 1'b0;
         engaged   = 1'b0;
         held      = '0;
         faults    = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] v);
         case (idx)
            CSR_PERIOD_TICKS:     period    = v[DUTY_W-1:0];
            CSR_DUTY_MIN:         dmin      = v[DUTY_W-1:0];
            CSR_DUTY_MAX:         dmax      = v[DUTY_W-1:0];
            CSR_AUTOPILOT_DUTY:   auto_duty = v[DUTY_W-1:0];
            CSR_SENSOR_THRESHOLD: threshold = v[SENSOR_W-1:0];
            default: ;
         endcase
      endfunction

      // active-low press edge; a release only re-arms the button
      function bit pressed(int unsigned b, logic lvl);
         if (!held[b]) begin
            if (lvl == PRESS) begin
               held[b] = 1'b1;
               return 1'b1;
            end
         end else if (lvl == REL) begin
            held[b] = 1'b0;
         end
         return 1'b0;
      endfunction

      function void take_word(req_type w);
         rsp_type    e;
         logic [8:0] nxt;
         if (w.mode == TICK) begin
            nxt = {1'b0, count} + 9'd1;
            if (nxt >= {1'b0, period}) nxt = '0;
            count = nxt[DUTY_W-1:0];
            if (count == '0) begin
               lvl_a = 1'b1;
               lvl_b = 1'b1;
            end
            if (count == duty_a) lvl_a = 1'b0;
            if (count == duty_b) lvl_b = 1'b0;
         end else begin
            if (engaged) begin
               if (w.sensor_a > threshold) duty_a = auto_duty;
               else if (w.sensor_c > threshold) duty_b = auto_duty;
               else begin
                  duty_a = dmin;
                  duty_b = dmin;
               end
            end
            if (pressed(BTN_TOGGLE, w.toggle_level)) engaged = !engaged;
            if (pressed(BTN_UP_A, w.up_a_level) && duty_a < dmax) duty_a = duty_a + 1'b1;
            if (pressed(BTN_DOWN_A, w.down_a_level) && duty_a > dmin) duty_a = duty_a - 1'b1;
            if (pressed(BTN_UP_B, w.up_b_level) && duty_b < dmax) duty_b = duty_b + 1'b1;
            if (pressed(BTN_DOWN_B, w.down_b_level) && duty_b > dmin) duty_b = duty_b - 1'b1;
         end
         e.pulse_a      = lvl_a;
         e.pulse_b      = lvl_b;
         e.autopilot_on = engaged;
         e.duty_a_now   = duty_a;
         e.duty_b_now   = duty_b;
         due.push_back(e);
      endfunction

      function void report(string what, rsp_type want, rsp_type got);
         faults++;
         if (faults <= 10)
            $display("%t %s: want a=%b b=%b ap=%b da=%0d db=%0d, got a=%b b=%b ap=%b da=%0d db=%0d",
                     $realtime, what, want.pulse_a, want.pulse_b, want.autopilot_on,
                     want.duty_a_now, want.duty_b_now, got.pulse_a, got.pulse_b,
                     got.autopilot_on, got.duty_a_now, got.duty_b_now);
      endfunction

      function void check_word(rsp_type got);
         rsp_type want;
         if (due.size() == 0) begin
            report("unexpected word", 'x, got);
            return;
         end
         want = due.pop_front();
         if (got.pulse_a !== want.pulse_a || got.pulse_b !== want.pulse_b ||
             got.autopilot_on !== want.autopilot_on ||
             got.duty_a_now !== want.duty_a_now || got.duty_b_now !== want.duty_b_now)
            report("word mismatch", want, got);
      endfunction

      function int unsigned outstanding();
         return due.size();
      endfunction

      function void close_out();
         if (due.size() != 0) begin
            if (faults < 10) $display("%0d result words never arrived", due.size());
            faults += due.size();
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   req_type               req_data = '0;
   logic                  rsp_stall = 1'b0;
   logic                  csr_we = 1'b0;
   csr_index_type         csr_index = CSR_PERIOD_TICKS;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_stall;
   logic                  rsp_valid;
   rsp_type               rsp_data;

   servo_shadow shadow;
   int unsigned stall_run = 0;
   int unsigned stall_kind = 0;

   dual_servo_pwm_with_trim_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // results are checked before the word taken on the same edge is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) shadow.check_word(rsp_data);
         if (req_valid && !req_stall) shadow.take_word(req_data);
      end
   end

   // receiver stall pattern: runs of none, light, heavy or solid stall
   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_kind <= $urandom_range(0, 3);
         stall_run  <= $urandom_range(4, 40);
      end else begin
         stall_run <= stall_run - 1;
      end
      case (stall_kind)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= 1'b1;
      endcase
   end

   function automatic req_type make_word(logic md, logic tg, logic ua, logic da, logic ub,
                                         logic db, int unsigned sa, int unsigned sc);
      req_type w;
      w.mode         = md;
      w.toggle_level = tg;
      w.up_a_level   = ua;
      w.down_a_level = da;
      w.up_b_level   = ub;
      w.down_b_level = db;
      w.sensor_a     = sa[SENSOR_W-1:0];
      w.sensor_c     = sc[SENSOR_W-1:0];
      return w;
   endfunction

   // readings cluster around the threshold so both rule branches are hit
   function automatic int unsigned pick_sensor(int unsigned thr);
      int v;
      case ($urandom_range(0, 5))
         0: return 0;
         1: return SENSOR_MAX;
         2: begin
            v = int'(thr) + int'($urandom_range(0, 4)) - 2;
            if (v < 0) v = 0;
            if (v > SENSOR_MAX) v = SENSOR_MAX;
            return v;
         end
         default: return $urandom_range(0, SENSOR_MAX);
      endcase
   endfunction

   function automatic req_type rand_word();
      int unsigned thr;
      thr = shadow.threshold;
      return make_word(1'($urandom_range(0, 1)), $urandom_range(0, 6) != 0,
                       $urandom_range(0, 9) > 2, $urandom_range(0, 9) > 2,
                       $urandom_range(0, 9) > 2, $urandom_range(0, 9) > 2,
                       pick_sensor(thr), pick_sensor(thr));
   endfunction

   task automatic send_word(req_type w);
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic pause(int unsigned n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (shadow.outstanding() != 0);
   endtask

   task automatic put_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      shadow.write_reg(idx, v);
   endtask

   // spare upper bits of the 8-bit registers are filled with noise
   task automatic write_regs(int unsigned p, int unsigned lo, int unsigned hi,
                             int unsigned ad, int unsigned th);
      put_reg(CSR_PERIOD_TICKS, {2'($urandom), 8'(p)});
      put_reg(CSR_DUTY_MIN, {2'($urandom), 8'(lo)});
      put_reg(CSR_DUTY_MAX, {2'($urandom), 8'(hi)});
      put_reg(CSR_AUTOPILOT_DUTY, {2'($urandom), 8'(ad)});
      put_reg(CSR_SENSOR_THRESHOLD, 10'(th));
      csr_we <= 1'b0;
   endtask

   task automatic directed_words();
      send_word(make_word(TICK, REL, REL, REL, REL, REL, 0, 0));
      send_word(make_word(TICK, PRESS, PRESS, PRESS, PRESS, PRESS, SENSOR_MAX, SENSOR_MAX));
      send_word(make_word(POLL, REL, REL, REL, REL, REL, 0, 0));
      send_word(make_word(POLL, REL, PRESS, REL, REL, REL, 0, 0));
      // held button acts only once
      send_word(make_word(POLL, REL, PRESS, REL, REL, REL, 0, 0));
      send_word(make_word(POLL, REL, REL, REL, REL, PRESS, SENSOR_MAX, SENSOR_MAX));
      send_word(make_word(POLL, REL, REL, PRESS, PRESS, REL, 0, SENSOR_MAX));
      send_word(make_word(POLL, PRESS, REL, REL, REL, REL, SENSOR_MAX, SENSOR_MAX));
      send_word(make_word(POLL, REL, REL, REL, REL, REL, SENSOR_MAX, 0));
      send_word(make_word(POLL, REL, REL, REL, REL, REL, THRESH_RST, THRESH_RST + 1));
      // readings equal to the threshold fall back to the minimum
      send_word(make_word(POLL, REL, REL, REL, REL, REL, THRESH_RST, THRESH_RST));
      send_word(make_word(POLL, REL, PRESS, REL, PRESS, REL, THRESH_RST + 1, 0));
      send_word(make_word(POLL, REL, REL, REL, REL, REL, 0, SENSOR_MAX));
      send_word(make_word(POLL, PRESS, PRESS, PRESS, PRESS, PRESS, 0, 0));
      send_word(make_word(POLL, REL, REL, REL, REL, REL, SENSOR_MAX, SENSOR_MAX));
      repeat (6) send_word(make_word(TICK, REL, REL, REL, REL, REL, 0, 0));
      drain();
   endtask

   task automatic random_phase();
      int unsigned n, sent, burst, gap, stop_at;
      n       = $urandom_range(30, 48);
      sent    = 0;
      stop_at = $urandom_range(5, n - 5);
      while (sent < n) begin
         burst = $urandom_range(1, 12);
         repeat (burst) begin
            if (sent < n) begin
               send_word(rand_word());
               sent++;
               if (sent == stop_at) drain();
            end
         end
         gap = $urandom_range(0, 6);
         if (gap != 0) pause(gap);
      end
      drain();
   endtask

   initial begin
      int unsigned p, lo, hi, ad, th;
      shadow = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      directed_words();
      for (int ph = 0; ph < 12; ph++) begin
         case (ph)
            0: write_regs(0, 0, 0, 0, 0);
            1: write_regs(255, 255, 255, 255, SENSOR_MAX);
            2: write_regs(1, 0, 255, 0, 0);
            3: write_regs(2, 0, 255, 1, SENSOR_MAX - 1);
            4: write_regs(6, 8, 2, 7, 30);
            default: begin
               p  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(2, 40);
               lo = $urandom_range(0, p);
               hi = $urandom_range(lo, (p + 4 > 255) ? 255 : p + 4);
               ad = $urandom_range(0, (p + 4 > 255) ? 255 : p + 4);
               th = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 60)
                                                : $urandom_range(0, SENSOR_MAX);
               write_regs(p, lo, hi, ad, th);
            end
         endcase
         random_phase();
      end
      repeat (5) @(posedge clock);
      shadow.close_out();
      if (shadow.faults == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/dspwm_pkg.sv
hw/rtl/dual_servo_pwm_with_trim_top.sv
test/dual_servo_pwm_with_trim_top_tb.sv
